@@ sv/bus_pkg.sv @@
`default_nettype none

package bus_pkg;

    // Store geometry. The element field is 32 bits wide, so VALUE_WIDTH stays at or below 32.
    localparam int DEPTH       = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = 6;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_ABSENT  = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] element;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             member;
        logic [CNT_W-1:0] count;
        logic             empty_res;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic search;
        logic decide;
        logic shift;
        logic commit;
    } bus_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic search_done;
        logic shift_needed;
        logic shift_done;
        logic out_free;
    } bus_sts_t;

endpackage

`default_nettype wire

@@ sv/bus_ctrl.sv @@
`default_nettype none

module bus_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire bus_pkg::bus_sts_t sts,
    output bus_pkg::bus_cmd_t     cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_DECIDE = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
                if (in_valid)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                if (sts.search_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = sts.shift_needed ? S_SHIFT : S_FINISH;
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.shift_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.commit = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/bus_datapath.sv @@
`default_nettype none

module bus_datapath (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [bus_pkg::CNT_W-1:0] cfg_data,
    input  wire bus_pkg::in_item_t        in_data,
    input  wire bus_pkg::bus_cmd_t        cmd,
    output bus_pkg::bus_sts_t             sts,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output bus_pkg::out_item_t            out_data
);

    localparam int IW = bus_pkg::IDX_W;
    localparam int CW = bus_pkg::CNT_W;
    localparam int VW = bus_pkg::VALUE_WIDTH;

    logic [VW-1:0] mem [bus_pkg::DEPTH];
    logic [VW-1:0] rd_data_reg;

    logic [1:0]    op_reg;
    logic [VW-1:0] elem_reg;
    logic [CW-1:0] capacity_reg;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic [CW-1:0] rd_idx_reg;
    logic [CW-1:0] rd_idx_next;
    logic [IW-1:0] pend_idx_reg;
    logic          pend_reg;
    logic          pend_next;
    logic [IW-1:0] wr_idx_reg;
    logic [IW-1:0] wr_idx_next;
    logic          found_reg;
    logic          found_next;
    logic [IW-1:0] slot_reg;
    logic [IW-1:0] slot_next;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    logic          out_valid_reg;
    bus_pkg::out_item_t out_reg;

    logic          rd_issue;
    logic          hit_now;
    logic          more_to_read;
    logic [CW-1:0] limit;
    logic          full;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [VW-1:0] mem_wd;

    assign more_to_read = rd_idx_reg < fill_reg;
    assign hit_now      = pend_reg && (rd_data_reg == elem_reg);
    assign limit        = (capacity_reg > CW'(bus_pkg::DEPTH)) ? CW'(bus_pkg::DEPTH)
                                                              : capacity_reg;
    assign full         = fill_reg >= limit;

    assign sts.search_done  = hit_now || (!pend_reg && !more_to_read);
    assign sts.shift_needed = (op_reg == bus_pkg::OP_REMOVE) && found_reg;
    assign sts.shift_done   = !pend_reg && !more_to_read;
    assign sts.out_free     = !out_valid_reg || out_ready;

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        pend_next   = 1'b0;
        wr_idx_next = wr_idx_reg;
        found_next  = found_reg;
        slot_next   = slot_reg;
        status_next = status_reg;
        fill_next   = fill_reg;
        rd_issue    = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = wr_idx_reg;
        mem_wd      = rd_data_reg;

        if (cmd.start)
        begin
            rd_idx_next = '0;
            found_next  = 1'b0;
        end
        if (cmd.search)
        begin
            rd_issue = more_to_read && !hit_now;
            if (hit_now)
            begin
                found_next = 1'b1;
                slot_next  = pend_idx_reg;
            end
        end
        if (cmd.decide)
        begin
            // Set up the compaction pass: read from the slot above the match.
            rd_idx_next = CW'(slot_reg) + CW'(1);
            wr_idx_next = slot_reg;
            case (op_reg)
                bus_pkg::OP_INSERT:
                begin
                    if (found_reg)
                    begin
                        status_next = bus_pkg::ST_PRESENT;
                    end
                    else if (full)
                    begin
                        status_next = bus_pkg::ST_FULL;
                    end
                    else
                    begin
                        status_next = bus_pkg::ST_DONE;
                        mem_we      = 1'b1;
                        mem_wa      = fill_reg[IW-1:0];
                        mem_wd      = elem_reg;
                        fill_next   = fill_reg + CW'(1);
                    end
                end
                bus_pkg::OP_REMOVE:
                begin
                    status_next = found_reg ? bus_pkg::ST_DONE : bus_pkg::ST_ABSENT;
                end
                default:
                begin
                    status_next = found_reg ? bus_pkg::ST_DONE : bus_pkg::ST_ABSENT;
                end
            endcase
        end
        if (cmd.shift)
        begin
            rd_issue = more_to_read;
            if (pend_reg)
            begin
                mem_we      = 1'b1;
                mem_wa      = wr_idx_reg;
                mem_wd      = rd_data_reg;
                wr_idx_next = wr_idx_reg + IW'(1);
            end
            if (!pend_reg && !more_to_read)
            begin
                fill_next = fill_reg - CW'(1);
            end
        end
        if (rd_issue)
        begin
            rd_idx_next = rd_idx_reg + CW'(1);
            pend_next   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_idx_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CW'(20);
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_data;
            end
            fill_reg  <= fill_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg   <= in_data.operation;
            elem_reg <= in_data.element[VW-1:0];
        end
        rd_idx_reg   <= rd_idx_next;
        pend_idx_reg <= rd_idx_reg[IW-1:0];
        wr_idx_reg   <= wr_idx_next;
        slot_reg     <= slot_next;
        status_reg   <= status_next;
        if (cmd.commit)
        begin
            out_reg.status    <= status_reg;
            out_reg.member    <= found_reg;
            out_reg.count     <= fill_reg;
            out_reg.empty_res <= (fill_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

@@ sv/bounded_unique_set_unit.sv @@
`default_nettype none

// Packed set of up to 32 distinct 32-bit values with a configurable capacity
// (cfg_data, reset 20, saturated to the store depth). Each input beat carries an
// operation (insert, remove, query; code 3 acts as a query) and an element, and
// yields exactly one output beat with a status, the prior member flag, the
// element count after the operation and an empty flag. Items are handled one
// at a time: the membership search reads one store entry per cycle and stops at
// the match, and a remove then shifts each entry above the match down one slot
// per cycle. Each item goes through search, decision, compaction (only for a
// remove that hits) and finish, where it waits for the output register to free
// up. The result sits in an output register, so a new item is taken while the
// last result still waits. Capacity must be written only while the block is
// idle; the block itself does not enforce this.
module bounded_unique_set_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [bus_pkg::CNT_W-1:0] cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire bus_pkg::in_item_t         in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output bus_pkg::out_item_t             out_data
);

    // The controller sequences search, decision, compaction and result commit;
    // the datapath owns the store, the fill count and the output register.
    bus_pkg::bus_cmd_t cmd;
    bus_pkg::bus_sts_t sts;

    bus_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bus_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

@@ tb/bounded_unique_set_unit_test.sv @@
`timescale 1ns / 100ps

// Shadow copy of the set and the queue of answers owed by the DUT.
class set_scoreboard;
    logic [31:0]        slots [bus_pkg::DEPTH];
    int                 fill;
    int                 capacity;
    bus_pkg::out_item_t answers [$];
    int unsigned        errors;
    int unsigned        noted;
    int unsigned        checked;
    int unsigned        full_answers;
    int                 peak_fill;

    function new();
        fill         = 0;
        capacity     = 20;
        errors       = 0;
        noted        = 0;
        checked      = 0;
        full_answers = 0;
        peak_fill    = 0;
    endfunction

    function void set_capacity(input logic [bus_pkg::CNT_W-1:0] value);
        capacity = int'(value);
    endfunction

    // Apply one accepted request to the shadow set and queue the answer it must produce.
    function void note_request(input bus_pkg::in_item_t req);
        int                 hit;
        int                 lim;
        logic [1:0]         st;
        bus_pkg::out_item_t ans;
        hit = -1;
        for (int i = 0; i < fill; i++)
        begin
            if (hit < 0 && slots[i] == req.element)
                hit = i;
        end
        lim = (capacity > bus_pkg::DEPTH) ? bus_pkg::DEPTH : capacity;
        case (req.operation)
            bus_pkg::OP_INSERT:
            begin
                if (hit >= 0)
                    st = bus_pkg::ST_PRESENT;
                else if (fill >= lim)
                begin
                    st = bus_pkg::ST_FULL;
                    full_answers++;
                end
                else
                begin
                    slots[fill] = req.element;
                    fill++;
                    st = bus_pkg::ST_DONE;
                end
            end
            bus_pkg::OP_REMOVE:
            begin
                if (hit >= 0)
                begin
                    for (int i = hit; i + 1 < fill; i++)
                        slots[i] = slots[i + 1];
                    fill--;
                    st = bus_pkg::ST_DONE;
                end
                else
                    st = bus_pkg::ST_ABSENT;
            end
            default:
                st = (hit >= 0) ? bus_pkg::ST_DONE : bus_pkg::ST_ABSENT;
        endcase
        if (fill > peak_fill)
            peak_fill = fill;
        ans.status    = st;
        ans.member    = (hit >= 0);
        ans.count     = bus_pkg::CNT_W'(fill);
        ans.empty_res = (fill == 0);
        answers.push_back(ans);
        noted++;
    endfunction

    function void check_result(input bus_pkg::out_item_t got);
        bus_pkg::out_item_t want;
        if (answers.size() == 0)
        begin
            $error("result beat with no pending answer: %p", got);
            errors++;
        end
        else
        begin
            want = answers.pop_front();
            checked++;
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.member !== want.member)
            begin
                $error("member: expected %0d, got %0d", want.member, got.member);
                errors++;
            end
            if (got.count !== want.count)
            begin
                $error("count: expected %0d, got %0d", want.count, got.count);
                errors++;
            end
            if (got.empty_res !== want.empty_res)
            begin
                $error("empty_res: expected %0d, got %0d", want.empty_res, got.empty_res);
                errors++;
            end
        end
    endfunction
endclass

module bounded_unique_set_unit_test;

    // The operation field has a fourth code with no name in the package.
    // The block treats it as a membership query, and it is driven as such.
    localparam logic [1:0] OP_QUERY_ALT = 2'd3;

    // This settle is longer than the longest time a result can take.
    localparam int DRAIN_CYCLES = 80;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [bus_pkg::CNT_W-1:0] cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    bus_pkg::in_item_t         in_data   = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    bus_pkg::out_item_t        out_data;

    // Set in the last phase so that neither side stalls at the end of the run.
    logic             calm       = 1'b0;
    int unsigned      stall_left = 0;
    int unsigned      settings   = 0;

    // Elements are mostly drawn from a small pool so that inserts collide,
    // removes find their target and the store can be driven to full.
    logic [31:0]      pool [40];

    set_scoreboard    book;

    bounded_unique_set_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Output side back-pressure. A stall holds out_ready low for a burst of random
    // length; between bursts the receiver takes every beat offered.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 6) == 0)
        begin
            stall_left <= $urandom_range(0, 8);
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Every result beat is compared with the oldest pending answer. The
    // values read here are the ones present just before the edge, which is
    // what the DUT itself saw.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            book.check_result(out_data);
    end

    // Offer one request and return at the edge that accepts it. The task is
    // always entered just after a rising edge. When a sender gap is chosen,
    // valid is dropped and the task waits out the gap; otherwise it simply stays high and the
    // payload changes, so valid never gets two updates in one time step.
    task automatic send_item(input logic [1:0] op, input logic [31:0] elem);
        bus_pkg::in_item_t req;
        req.operation = op;
        req.element   = elem;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        book.note_request(req);
    endtask

    // Capacity may only change while the block is idle, so the input side is
    // parked and every pending answer must have come back first. Since each
    // request yields exactly one result, an empty queue means the block is done.
    task automatic write_capacity(input logic [bus_pkg::CNT_W-1:0] value);
        in_valid <= 1'b0;
        while (book.answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        book.set_capacity(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [31:0] pick_element();
        if ($urandom_range(0, 99) < 85)
            return pool[$urandom_range(0, 39)];
        return $urandom();
    endfunction

    initial
    begin
        int          cap_plan [8];
        int          ins_plan [8];
        int          rm_plan  [8];
        int          len_plan [8];
        int unsigned r;
        logic [1:0]  op;

        book = new();
        pool[0] = 32'h0000_0000;
        pool[1] = 32'hFFFF_FFFF;
        pool[2] = 32'h8000_0000;
        pool[3] = 32'h7FFF_FFFE;
        for (int i = 4; i < 40; i++)
            pool[i] = $urandom();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, at the reset capacity of 20. Lookups and removes on
        // an empty set come first, then a duplicate insert, the unnamed query
        // code, and removes at the bottom, middle and top of the store so that
        // the compaction shift is seen from every position.
        send_item(bus_pkg::OP_QUERY,  32'h0000_0000);
        send_item(bus_pkg::OP_REMOVE, 32'h0000_0000);
        send_item(bus_pkg::OP_INSERT, 32'h0000_0000);
        send_item(bus_pkg::OP_INSERT, 32'hFFFF_FFFF);
        send_item(bus_pkg::OP_INSERT, 32'h0000_0000);
        send_item(OP_QUERY_ALT,       32'hFFFF_FFFF);
        send_item(bus_pkg::OP_REMOVE, 32'h0000_0000);
        send_item(bus_pkg::OP_QUERY,  32'h0000_0000);
        send_item(bus_pkg::OP_QUERY,  32'hFFFF_FFFF);
        send_item(bus_pkg::OP_INSERT, 32'h8000_0000);
        send_item(bus_pkg::OP_INSERT, 32'h0000_0001);
        send_item(bus_pkg::OP_INSERT, 32'h7FFF_FFFE);
        send_item(bus_pkg::OP_REMOVE, 32'h8000_0000);
        send_item(bus_pkg::OP_REMOVE, 32'h7FFF_FFFE);
        send_item(bus_pkg::OP_REMOVE, 32'hFFFF_FFFF);
        send_item(bus_pkg::OP_REMOVE, 32'h0000_0001);

        // A capacity of one: the second distinct value must be refused.
        write_capacity(6'd1);
        send_item(bus_pkg::OP_INSERT, 32'h0000_0005);
        send_item(bus_pkg::OP_INSERT, 32'h0000_0006);
        send_item(bus_pkg::OP_INSERT, 32'h0000_0005);
        send_item(OP_QUERY_ALT,       32'h0000_0006);

        // A capacity of zero: duplicates are still reported as present ahead
        // of the full check, and nothing can be added even to an empty set.
        write_capacity(6'd0);
        send_item(bus_pkg::OP_INSERT, 32'h0000_0006);
        send_item(bus_pkg::OP_INSERT, 32'h0000_0005);
        send_item(bus_pkg::OP_REMOVE, 32'h0000_0005);
        send_item(bus_pkg::OP_INSERT, 32'h0000_0005);

        // Random phases. The first saturates the register (63 clips to the
        // store depth) and is insert heavy, so the store fills to 32. The next
        // drops capacity to 4 with the store still full, so inserts are
        // refused until removes bring the size under the new limit. Later
        // phases mix capacities from the extremes and the middle; the last
        // runs without any idling on either side.
        cap_plan = '{63, 4, 0, 32, 1, 40, 0, 20};
        cap_plan[6] = $urandom_range(2, 31);
        ins_plan = '{75, 25, 50, 45, 40, 60, 40, 40};
        rm_plan  = '{10, 45, 25, 35, 40, 25, 40, 40};
        len_plan = '{200, 200, 120, 250, 120, 250, 200, 250};

        for (int p = 0; p < 8; p++)
        begin
            write_capacity(bus_pkg::CNT_W'(cap_plan[p]));
            if (p == 7)
                calm = 1'b1;
            for (int n = 0; n < len_plan[p]; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < ins_plan[p])
                    op = bus_pkg::OP_INSERT;
                else if (r < ins_plan[p] + rm_plan[p])
                    op = bus_pkg::OP_REMOVE;
                else if (r % 4 == 0)
                    op = OP_QUERY_ALT;
                else
                    op = bus_pkg::OP_QUERY;
                send_item(op, pick_element());
            end
        end

        // Let the last answers come back, then give the block time to show
        // any stray beat it should not produce.
        in_valid <= 1'b0;
        while (book.answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests and checked %0d results over %0d capacity settings.",
                 book.noted, book.checked, settings);
        $display("The set reached %0d elements and %0d inserts were refused as full.",
                 book.peak_fill, book.full_answers);
        if (book.errors == 0 && book.answers.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // This limit is well beyond what a correct run needs, even with every stall at its longest.
    initial
    begin
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
